// File: rtl/core/mxu_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix unit.
// Used by every module of the unit but mxu_ram; depends on nothing else.
package mxu_pkg;

  // Matrix geometry and number format.
  localparam int DIM         = 4;
  localparam int FRAC_BITS   = 16;
  localparam int CELLS       = DIM * DIM;
  localparam int IDX_W       = $clog2(CELLS);
  localparam int K_W         = $clog2(DIM);
  localparam int VAL_W       = 32;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int ELEM_IDX_W  = 4;
  localparam int CMD_W       = 3;

  // Accumulator holds DIM shifted products exactly, plus a guard bit.
  localparam int ACC_W       = PROD_W - FRAC_BITS + K_W + 1;

  // Stream packing.
  localparam int IN_LEFT_LSB   = ELEM_IDX_W;
  localparam int IN_RIGHT_LSB  = IN_LEFT_LSB + VAL_W;
  localparam int IN_SCALAR_LSB = IN_RIGHT_LSB + VAL_W;
  localparam int IN_BITS       = IN_SCALAR_LSB + VAL_W;
  localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_VAL_LSB   = ELEM_IDX_W;
  localparam int OUT_BITS      = OUT_VAL_LSB + VAL_W;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PRODUCT    = 3'd0,
    CMD_ADD        = 3'd1,
    CMD_SUB        = 3'd2,
    CMD_SCALAR_MUL = 3'd3,
    CMD_SCALAR_ADD = 3'd4,
    CMD_SCALAR_SUB = 3'd5
  } cmd_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_ISSUE = 1'b1
  } bk_state_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] right;
  } store_wr_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [VAL_W-1:0] scalar;
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0] addr_left;
    logic [IDX_W-1:0] addr_right;
    logic             en;
  } store_rd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] pos;
    logic             first;
    logic             last;
    logic [VAL_W-1:0] scalar;
  } step_tag_t;

endpackage

// File: rtl/core/mxu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module mxu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/mxu_front.sv
// Front end of the matrix unit: unpacks input items, writes both element
// stores and turns a final item with a valid command into a job. Uses mxu_pkg.
module mxu_front (
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mxu_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [mxu_pkg::CMD_W-1:0]         in_tuser,
  input  logic                              in_tlast,
  input  logic                              can_accept,
  output mxu_pkg::store_wr_t                store_wr,
  output mxu_pkg::job_t                     job,
  output logic                              job_push
);
  import mxu_pkg::*;

  logic                  accept;
  logic [ELEM_IDX_W-1:0] elem_idx;
  logic                  idx_ok;
  logic                  cmd_ok;

  assign in_tready = can_accept;
  assign accept    = in_tvalid && can_accept;
  assign elem_idx  = in_tdata[ELEM_IDX_W-1:0];
  assign idx_ok    = 32'(elem_idx) < 32'(CELLS);
  assign cmd_ok    = in_tuser inside {[CMD_PRODUCT:CMD_SCALAR_SUB]};

  always_comb begin
    store_wr.en    = accept && idx_ok;
    store_wr.addr  = IDX_W'(elem_idx);
    store_wr.left  = in_tdata[IN_LEFT_LSB +: VAL_W];
    store_wr.right = in_tdata[IN_RIGHT_LSB +: VAL_W];
  end

  // Unknown commands on a final item only load the pair.
  assign job_push   = accept && in_tlast && cmd_ok;
  assign job.cmd    = cmd_t'(in_tuser);
  assign job.scalar = in_tdata[IN_SCALAR_LSB +: VAL_W];

endmodule

// File: rtl/core/mxu_job_queue.sv
// Short job queue between the front and back of the matrix unit.
// Holds command and scalar of pending computations. Uses mxu_pkg.
module mxu_job_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mxu_pkg::job_t push_job,
  input  logic          pop,
  output mxu_pkg::job_t head_job,
  output logic          head_valid,
  output logic          full
);
  import mxu_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign head_valid = count_r != '0;
  assign full       = count_r == QCNT_W'(QUEUE_DEPTH);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/core/mxu_back.sv
// Back end of the matrix unit: sequences store reads for one job, runs the
// multiply and accumulate pipeline, saturates and holds the output register.
// Uses mxu_pkg; reads the element stores built in the top level.
module mxu_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mxu_pkg::job_t                      job,
  input  logic                               job_valid,
  output logic                               job_pop,
  output logic                               issue_busy,
  output mxu_pkg::store_rd_t                 store_rd,
  input  logic [mxu_pkg::VAL_W-1:0]          left_data,
  input  logic [mxu_pkg::VAL_W-1:0]          right_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mxu_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import mxu_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

  bk_state_t state_r, state_nxt;

  cmd_t             cmd_r, cmd_nxt;
  logic [VAL_W-1:0] scalar_r, scalar_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [K_W-1:0]   row_r, row_nxt;
  logic [K_W-1:0]   col_r, col_nxt;
  logic [K_W-1:0]   k_r, k_nxt;

  logic stall;
  logic advance;
  logic is_prod;
  logic step_last;
  logic elem_last;

  step_tag_t s1_tag_r, s1_tag_nxt;
  logic      s1_valid_r;
  step_tag_t s2_tag_r;
  logic      s2_valid_r;
  logic signed [PROD_W-1:0] mul_r;
  logic signed [VAL_W-1:0]  lhs_r;
  logic signed [VAL_W-1:0]  rhs_r;
  logic [VAL_W-1:0]         opnd_b;

  logic signed [PROD_W-1:0] mul_shift;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_sum;
  logic                     sat_hi;
  logic                     sat_lo;
  logic                     load_out;

  logic                  out_valid_r, out_valid_nxt;
  logic [ELEM_IDX_W-1:0] out_idx_r;
  logic [VAL_W-1:0]      out_val_r;
  logic                  out_ovf_r;
  logic                  out_last_r;

  // Issue and pipeline freeze while a result waits in the output register.
  assign stall     = out_valid_r && !out_tready;
  assign is_prod   = cmd_r == CMD_PRODUCT;
  assign step_last = !is_prod || (k_r == K_W'(DIM - 1));
  assign elem_last = pos_r == IDX_W'(CELLS - 1);
  assign advance   = (state_r == BK_ISSUE) && !stall;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          state_nxt = BK_ISSUE;
        end
      end
      BK_ISSUE: begin
        if (advance && step_last && elem_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    job_pop    = 1'b0;
    issue_busy = 1'b0;
    case (state_r)
      BK_IDLE:  job_pop    = job_valid;
      BK_ISSUE: issue_busy = 1'b1;
      default:  issue_busy = 1'b0;
    endcase
  end

  // Position counters: row and column of the result, k walks the dot product.
  always_comb begin
    cmd_nxt    = cmd_r;
    scalar_nxt = scalar_r;
    pos_nxt    = pos_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    k_nxt      = k_r;
    if (job_pop) begin
      cmd_nxt    = job.cmd;
      scalar_nxt = job.scalar;
      pos_nxt    = '0;
      row_nxt    = '0;
      col_nxt    = '0;
      k_nxt      = '0;
    end else if (advance) begin
      if (!step_last) begin
        k_nxt = k_r + 1'b1;
      end else begin
        k_nxt   = '0;
        pos_nxt = pos_r + 1'b1;
        if (row_r == K_W'(DIM - 1)) begin
          row_nxt = '0;
          col_nxt = col_r + 1'b1;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    store_rd.en = advance;
    if (is_prod) begin
      store_rd.addr_left  = IDX_W'(k_r) * IDX_W'(DIM) + IDX_W'(row_r);
      store_rd.addr_right = IDX_W'(col_r) * IDX_W'(DIM) + IDX_W'(k_r);
    end else begin
      store_rd.addr_left  = pos_r;
      store_rd.addr_right = pos_r;
    end
  end

  always_comb begin
    s1_tag_nxt.cmd    = cmd_r;
    s1_tag_nxt.pos    = pos_r;
    s1_tag_nxt.first  = !is_prod || (k_r == '0);
    s1_tag_nxt.last   = step_last;
    s1_tag_nxt.scalar = scalar_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    scalar_r <= scalar_nxt;
    pos_r    <= pos_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    k_r      <= k_nxt;
  end

  // Stage 1: store data arrives, tag follows it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!stall) begin
      s1_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_tag_r <= s1_tag_nxt;
    end
  end

  // Stage 2: one 32x32 multiply; scalar commands use the scalar operand.
  always_comb begin
    case (s1_tag_r.cmd)
      CMD_SCALAR_MUL, CMD_SCALAR_ADD, CMD_SCALAR_SUB: opnd_b = s1_tag_r.scalar;
      default:                                        opnd_b = right_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (!stall) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s2_tag_r <= s1_tag_r;
      mul_r    <= $signed(left_data) * $signed(opnd_b);
      lhs_r    <= $signed(left_data);
      rhs_r    <= $signed(opnd_b);
    end
  end

  // Stage 3: floor-shift or add/sub, accumulate exactly, then saturate.
  assign mul_shift = mul_r >>> FRAC_BITS;

  always_comb begin
    case (s2_tag_r.cmd)
      CMD_PRODUCT, CMD_SCALAR_MUL: term = ACC_W'(mul_shift);
      CMD_ADD, CMD_SCALAR_ADD:     term = ACC_W'(lhs_r) + ACC_W'(rhs_r);
      CMD_SUB, CMD_SCALAR_SUB:     term = ACC_W'(lhs_r) - ACC_W'(rhs_r);
      default:                     term = '0;
    endcase
  end

  assign acc_sum  = (s2_tag_r.first ? '0 : acc_r) + term;
  assign sat_hi   = acc_sum > SAT_HI;
  assign sat_lo   = acc_sum < SAT_LO;
  assign load_out = s2_valid_r && s2_tag_r.last && !stall;

  always_ff @(posedge clk) begin
    if (s2_valid_r && !stall) begin
      acc_r <= acc_sum;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx_r  <= ELEM_IDX_W'(s2_tag_r.pos);
      out_ovf_r  <= sat_hi || sat_lo;
      out_last_r <= s2_tag_r.pos == IDX_W'(CELLS - 1);
      if (sat_hi) begin
        out_val_r <= VAL_W'(SAT_HI);
      end else if (sat_lo) begin
        out_val_r <= VAL_W'(SAT_LO);
      end else begin
        out_val_r <= acc_sum[VAL_W-1:0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_val_r, out_idx_r});

endmodule

// File: rtl/core/matrix4x4_arith_unit.sv
// 4x4 Q16.16 matrix unit: product, element-wise add/sub, scalar mul/add/sub.
// Loading is one item per cycle while the input is ready; after a final item the
// input is ready again once the back end has issued every store read of the job.
// Reset (rst_n low, synchronous) clears the sequencer state, valid flags and queue
// pointers and count; position counters, data registers and stores keep no reset.
//
// Structure
//   The front (mxu_front) accepts input items and writes the left and right
//   element of each item into two single-port-read stores (mxu_ram). A final
//   item carrying a known command is turned into a job (command and scalar)
//   and pushed into a two-entry queue (mxu_job_queue).
//   The back (mxu_back) pops a job and walks the sixteen result positions.
//   For a product it reads one left/right pair per cycle unless the output stalls,
//   via a shared multiplier, four steps per result; other commands take one step
//   per result. Each step passes a store read, a 32x32 multiply register and an
//   exact saturating accumulate; each result's last step loads the output register.
//
// Flow control
//   The input side stalls while a job waits in the queue or while the back
//   is still issuing store reads, since later items would overwrite stores
//   the job still needs. A job is popped, its store reads are issued (64 for a
//   product, 16 for an element-wise or scalar job) and the input is released.
//   Issue and pipeline freeze while a result waits in the output register; a
//   job can still be popped, and a new item can still be taken while the last
//   results drain.
//
// Depends on mxu_pkg, mxu_ram, mxu_front, mxu_job_queue and mxu_back.
module matrix4x4_arith_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input item stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // From bit 0: element_index[3:0], left_value[31:0], right_value[31:0],
  // scalar_value[31:0], then zero padding.
  input  logic [mxu_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command[2:0].
  input  logic [mxu_pkg::CMD_W-1:0]         in_tuser,
  // final_element.
  input  logic                              in_tlast,
  // Result item stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // From bit 0: result_index[3:0], result_value[31:0], then zero padding.
  output logic [mxu_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // overflow_flag.
  output logic                              out_tuser,
  // end_of_matrix.
  output logic                              out_tlast
);
  import mxu_pkg::*;

  store_wr_t        store_wr;
  store_rd_t        store_rd;
  job_t             push_job;
  job_t             head_job;
  logic             job_push;
  logic             job_pop;
  logic             head_valid;
  logic             q_full;
  logic             issue_busy;
  logic             can_accept;
  logic [VAL_W-1:0] left_data;
  logic [VAL_W-1:0] right_data;

  // New items may only land in the stores once the pending job has read them.
  assign can_accept = !head_valid && !issue_busy;

  mxu_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .can_accept (can_accept),
    .store_wr   (store_wr),
    .job        (push_job),
    .job_push   (job_push)
  );

  // Left and right element stores, column-major.
  mxu_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CELLS)
  ) u_left_store (
    .clk     (clk),
    .wr_en   (store_wr.en),
    .wr_addr (store_wr.addr),
    .wr_data (store_wr.left),
    .rd_en   (store_rd.en),
    .rd_addr (store_rd.addr_left),
    .rd_data (left_data)
  );

  mxu_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CELLS)
  ) u_right_store (
    .clk     (clk),
    .wr_en   (store_wr.en),
    .wr_addr (store_wr.addr),
    .wr_data (store_wr.right),
    .rd_en   (store_rd.en),
    .rd_addr (store_rd.addr_right),
    .rd_data (right_data)
  );

  mxu_job_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (push_job),
    .pop        (job_pop),
    .head_job   (head_job),
    .head_valid (head_valid),
    .full       (q_full)
  );

  mxu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (head_job),
    .job_valid  (head_valid),
    .job_pop    (job_pop),
    .issue_busy (issue_busy),
    .store_rd   (store_rd),
    .left_data  (left_data),
    .right_data (right_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A job is never pushed into a full queue.
  a_no_push_when_full : assert property (
    @(posedge clk) disable iff (!rst_n) job_push |-> !q_full
  ) else $error("job pushed into full queue");

  // A saturated result carries one of the two clamp values.
  a_ovf_clamped : assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[OUT_VAL_LSB +: VAL_W] == 32'h7FFF_FFFF ||
       out_tdata[OUT_VAL_LSB +: VAL_W] == 32'h8000_0000)
  ) else $error("overflow flag without clamped value");

  // The end-of-matrix marker only comes with the last position.
  a_last_position : assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (out_tdata[ELEM_IDX_W-1:0] == ELEM_IDX_W'(CELLS - 1))
  ) else $error("end of matrix on wrong position");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for matrix4x4_arith_unit: loads Q16.16 matrices over the input
// stream, predicts all sixteen result elements of each job and checks the result stream.
// Depends on mxu_pkg and the RTL of the matrix unit; reads no files.
module testbench;
  import mxu_pkg::*;

  localparam int MAT_DIM   = 4;
  localparam int MAT_CELLS = MAT_DIM * MAT_DIM;
  localparam int Q_FRAC    = 16;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  // Codes 6 and 7 are not operations; a final item carrying one only loads.
  localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;

  localparam int RANDOM_ITEMS  = 230;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [3:0]  index;
    logic [31:0] value;
    logic        ovf;
    logic        last;
  } result_elem_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  // Mirror of the element stores and the results still owed by the block.
  logic [31:0]  left_mirror [MAT_CELLS];
  logic [31:0]  right_mirror[MAT_CELLS];
  result_elem_t expected_elems[$];
  result_elem_t want;
  int           error_count = 0;
  int           sink_stall = 0;
  logic         steady_mode = 1'b0;

  matrix4x4_arith_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] corner_value(int n);
    case (n % 8)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return 32'hFFFF_0000;
      4: return 32'h0000_0000;
      5: return 32'hFFFF_FFFF;
      6: return 32'h0000_0001;
      default: return 32'h0003_8000;
    endcase
  endfunction

  // Mix of full-range values (product overflow), small Q16.16 numbers and corners.
  function automatic logic [31:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 8) return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    return corner_value($urandom_range(0, 7));
  endfunction

  function automatic longint sx(logic [31:0] x);
    return longint'($signed(x));
  endfunction

  // Exact product with the fraction bits dropped toward minus infinity.
  function automatic longint q_product(logic [31:0] a, logic [31:0] b);
    return (sx(a) * sx(b)) >>> Q_FRAC;
  endfunction

  // Updates the store mirror for one accepted item and, on a final item with a
  // known command, queues the sixteen result elements in position order.
  function automatic void predict_item(logic [CMD_W-1:0] cmd, logic [3:0] idx,
                                       logic [31:0] lv, logic [31:0] rv,
                                       logic [31:0] sv, logic fin);
    result_elem_t elem;
    longint       acc;
    int           p;
    int           k;
    int           row;
    int           col;
    left_mirror[idx]  = lv;
    right_mirror[idx] = rv;
    if (!fin || cmd > CMD_SCALAR_SUB) return;
    for (p = 0; p < MAT_CELLS; p++) begin
      row = p % MAT_DIM;
      col = p / MAT_DIM;
      case (cmd)
        CMD_PRODUCT: begin
          acc = 0;
          for (k = 0; k < MAT_DIM; k++) begin
            acc += q_product(left_mirror[k * MAT_DIM + row], right_mirror[col * MAT_DIM + k]);
          end
        end
        CMD_ADD:        acc = sx(left_mirror[p]) + sx(right_mirror[p]);
        CMD_SUB:        acc = sx(left_mirror[p]) - sx(right_mirror[p]);
        CMD_SCALAR_MUL: acc = q_product(left_mirror[p], sv);
        CMD_SCALAR_ADD: acc = sx(left_mirror[p]) + sx(sv);
        default:        acc = sx(left_mirror[p]) - sx(sv);
      endcase
      elem.index = p[3:0];
      elem.last  = (p == MAT_CELLS - 1);
      elem.ovf   = (acc > Q_MAX) || (acc < Q_MIN);
      if (acc > Q_MAX) begin
        elem.value = 32'h7FFF_FFFF;
      end else if (acc < Q_MIN) begin
        elem.value = 32'h8000_0000;
      end else begin
        elem.value = acc[31:0];
      end
      expected_elems.push_back(elem);
    end
  endfunction

  // Sends one item after an optional gap; valid stays high on return so that
  // a back-to-back item needs no second assignment in the same step.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [3:0] idx,
                           input logic [31:0] lv, input logic [31:0] rv,
                           input logic [31:0] sv, input logic fin);
    int gap;
    gap = steady_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, sv, rv, lv, idx};
    in_tuser  <= cmd;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    predict_item(cmd, idx, lv, rv, sv, fin);
  endtask

  // Holds the input side off until every queued result element has come back.
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_elems.size() != 0);
  endtask

  // The first job needs every entry written, so this test loads all sixteen.
  task automatic test_full_load_product();
    int i;
    for (i = 0; i < MAT_CELLS; i++) begin
      send_item((i == MAT_CELLS - 1) ? CMD_PRODUCT : CMD_W'(i % 8), i[3:0],
                corner_value(i), corner_value(i * 3 + 1), corner_value(i + 5),
                i == MAT_CELLS - 1);
    end
  endtask

  // One final item per remaining operation, operands chosen to saturate.
  task automatic test_each_command();
    send_item(CMD_ADD, 4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b1);
    send_item(CMD_SUB, 4'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1);
    send_item(CMD_SCALAR_MUL, 4'd2, 32'h0002_0000, 32'h1, 32'h8000_0000, 1'b1);
    send_item(CMD_SCALAR_ADD, 4'd3, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_item(CMD_SCALAR_SUB, 4'd15, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
  endtask

  // Unknown commands on a final item only load; the sum afterwards shows the
  // stores kept those loads.
  task automatic test_unknown_commands();
    send_item(CMD_BAD_LO, 4'd5, 32'h0001_8000, 32'hFFFE_0000, 32'h7FFF_FFFF, 1'b1);
    send_item(CMD_BAD_HI, 4'd10, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_item(CMD_ADD, 4'd6, 32'h4000_0000, 32'h4000_0000, 32'h0, 1'b1);
  endtask

  task automatic test_random_jobs();
    int sent;
    int kind;
    int n;
    int i;
    int j;
    int tmp;
    int order[MAT_CELLS];
    logic [CMD_W-1:0] fin_cmd;
    sent = 0;
    wait_all_results();
    while (sent < RANDOM_ITEMS) begin
      steady_mode <= ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 7) == 0) wait_all_results();
      kind = $urandom_range(0, 99);
      fin_cmd = ($urandom_range(0, 9) == 0) ? CMD_W'($urandom_range(6, 7))
                                            : CMD_W'($urandom_range(0, 5));
      if (kind < 50) begin
        // Whole matrix load, in order or shuffled.
        for (i = 0; i < MAT_CELLS; i++) order[i] = i;
        if ($urandom_range(0, 1)) begin
          for (i = MAT_CELLS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
        end
        n = MAT_CELLS;
      end else begin
        // Partial update or noise: a few random positions.
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) order[i] = $urandom_range(0, MAT_CELLS - 1);
      end
      for (i = 0; i < n; i++) begin
        if (i == n - 1 && kind < 85) begin
          send_item(fin_cmd, order[i][3:0], rand_value(), rand_value(), rand_value(), 1'b1);
        end else begin
          send_item(CMD_W'($urandom_range(0, 7)), order[i][3:0], rand_value(), rand_value(),
                    rand_value(), 1'b0);
        end
      end
      sent += n;
    end
  endtask

  // Result sink: random stalls unless a steady stretch is running.
  always @(posedge clk) begin
    if (!rst_n || steady_mode) begin
      out_tready <= 1'b1;
      sink_stall <= 0;
    end else if (sink_stall > 0) begin
      out_tready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_tready <= 1'b0;
      sink_stall <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Every accepted result element is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_elems.size() == 0) begin
        $error("result element with nothing expected: index %0d value %0h",
               out_tdata[3:0], out_tdata[35:4]);
        error_count++;
      end else begin
        want = expected_elems.pop_front();
        if (out_tdata[3:0] !== want.index) begin
          $error("result_index expected %0d got %0d", want.index, out_tdata[3:0]);
          error_count++;
        end
        if (out_tdata[35:4] !== want.value) begin
          $error("result_value expected %08h got %08h", want.value, out_tdata[35:4]);
          error_count++;
        end
        if (out_tuser !== want.ovf) begin
          $error("overflow_flag expected %0b got %0b", want.ovf, out_tuser);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("end_of_matrix expected %0b got %0b", want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_full_load_product();
    test_each_command();
    test_unknown_commands();
    test_random_jobs();
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mxu_pkg.sv
rtl/core/mxu_ram.sv
rtl/core/mxu_front.sv
rtl/core/mxu_job_queue.sv
rtl/core/mxu_back.sv
rtl/core/matrix4x4_arith_unit.sv
tb/testbench.sv
